// ----- sv/walm_pkg.sv -----
`default_nettype none
package walm_pkg;
   localparam int MaxChannels = 2;
   localparam int WindowDepth = 1024;
   localparam int SampleBits = 16;
   localparam int SqSumBits = 42;
   localparam int NumBits = 12;

   typedef struct packed {
      logic                  channel;
      logic signed [15:0]    sample;
      logic                  eob;
   } item_type;

   localparam logic [0:0] CsrChannelCount = 1'b0;
   localparam logic [0:0] CsrWindowLen = 1'b1;
endpackage
`default_nettype wire

// ----- sv/walm_front.sv -----
`default_nettype none
// accepts items, drops samples of unused channels unless they end a block, queues the rest
module walm_front
   import walm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire item_type req_item,
   input  wire logic [1:0] nch,
   output logic          q_valid,
   input  wire logic     q_pop,
   output item_type      q_item
);
   item_type    buf_ff [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        rd_ff, wr_ff;
   logic        push, keep, in_use;

   assign req_stall = (cnt_ff == 2'd2);
   // channel 0 is always in use, channel 1 only when two channels are active
   assign in_use = !req_item.channel || (nch >= 2'd2);
   assign keep = in_use || req_item.eob;
   assign push = req_valid && !req_stall && keep;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = buf_ff[rd_ff];
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= ~wr_ff;
         if (q_pop && q_valid) rd_ff <= ~rd_ff;
      end
      if (push) buf_ff[wr_ff] <= req_item;
   end
`ifndef SYNTHESIS
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   a_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> req_stall) else $error("full queue not stalling");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !q_valid) else $error("empty queue valid");
`endif
endmodule
`default_nettype wire

// ----- sv/walm_back.sv -----
`default_nettype none
// stores samples; on block end sweeps windows, divides, emits results
module walm_back
   import walm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   output logic             q_pop,
   input  wire item_type    q_item,
   input  wire logic [1:0]  nch,
   input  wire logic [10:0] wlen,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_channel_out,
   output logic signed [15:0] rsp_peak,
   output logic signed [15:0] rsp_minimum,
   output logic signed [15:0] rsp_mean,
   output logic [30:0]      rsp_power,
   output logic             rsp_last
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001, S_CLR = 8'b00000010, S_RD = 8'b00000100,
      S_ACC = 8'b00001000, S_DIVM = 8'b00010000, S_DIVP = 8'b00100000,
      S_OUT = 8'b01000000, S_WAIT = 8'b10000000
   } state_type;
   state_type state_ff;

   logic signed [15:0] mem [2*WindowDepth];
   logic signed [15:0] rdata_ff;
   logic [9:0]  wp_ff [2];
   logic [10:0] clr_ff;
   logic [10:0] k_ff;
   logic        ch_ff, ocnt_ff;
   logic signed [15:0] peak_ff, mini_ff, mean_ff;
   logic signed [26:0] tot_ff;
   logic [SqSumBits-1:0] sq_ff [2];
   logic [SqSumBits-1:0] rem_ff;
   logic [SqSumBits-1:0] quo_ff;
   logic [5:0]  bit_ff;
   logic        neg_ff;
   logic [30:0] pw_ff [2];
   logic [1:0]  nch_eff;
   logic [10:0] len;
   logic [NumBits-1:0] den;
   logic [9:0]  rpos;
   logic signed [31:0] prod;
   logic [SqSumBits:0] trial;
   logic        outv_ff;

   assign nch_eff = (nch == 2'd0) ? 2'd1 : ((nch > 2'd2) ? 2'd2 : nch);
   assign len = (wlen == 11'd0) ? 11'd1 : ((wlen > 11'd1024) ? 11'd1024 : wlen);
   assign den = (state_ff == S_DIVM) ? ((nch_eff == 2'd2) ? {len, 1'b0} : {1'b0, len})
                                     : {1'b0, len};
   assign rpos = wp_ff[ch_ff] - k_ff[9:0] - 10'd1;
   assign prod = rdata_ff * rdata_ff;
   assign trial = {rem_ff, quo_ff[SqSumBits-1]} - {{(SqSumBits-NumBits+1){1'b0}}, den};
   assign q_pop = (state_ff == S_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (q_pop && q_item.channel < nch_eff) mem[{q_item.channel, wp_ff[q_item.channel]}]
         <= q_item.sample;
      else if (state_ff == S_CLR) mem[clr_ff] <= '0;
      rdata_ff <= mem[{ch_ff, rpos}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         wp_ff[0] <= '0;
         wp_ff[1] <= '0;
         outv_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + 11'd1;
               if (clr_ff == 11'(2*WindowDepth-1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (q_pop) begin
               if (q_item.channel < nch_eff)
                  wp_ff[q_item.channel] <= wp_ff[q_item.channel] + 10'd1;
               if (q_item.eob) begin
                  state_ff <= S_RD;
                  ch_ff <= 1'b0; k_ff <= '0;
                  peak_ff <= 16'sh8000; mini_ff <= 16'sh7fff; tot_ff <= '0;
                  sq_ff[0] <= '0; sq_ff[1] <= '0;
               end
            end
            S_RD: begin
               // address issued; data registered next cycle
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (rdata_ff > peak_ff) peak_ff <= rdata_ff;
               if (rdata_ff < mini_ff) mini_ff <= rdata_ff;
               tot_ff <= tot_ff + 27'(rdata_ff);
               sq_ff[ch_ff] <= sq_ff[ch_ff] + SqSumBits'(unsigned'(prod));
               if (k_ff + 11'd1 == len) begin
                  k_ff <= '0;
                  if ({1'b0, ch_ff} + 2'd1 == nch_eff) begin
                     rem_ff <= '0; bit_ff <= '0;
                     state_ff <= S_DIVM;
                  end else begin
                     ch_ff <= 1'b1; state_ff <= S_RD;
                  end
               end else begin
                  k_ff <= k_ff + 11'd1; state_ff <= S_RD;
               end
               if (k_ff + 11'd1 == len && {1'b0, ch_ff} + 2'd1 == nch_eff) begin
                  logic signed [26:0] t;
                  t = tot_ff + 27'(rdata_ff);
                  neg_ff <= t[26];
                  quo_ff <= SqSumBits'(unsigned'(t[26] ? -t : t));
                  ocnt_ff <= 1'b0;
               end
            end
            S_DIVM, S_DIVP: begin
               // restoring division, one quotient bit per cycle
               if (bit_ff == 6'(SqSumBits-1)) begin
                  bit_ff <= '0; rem_ff <= '0;
                  if (state_ff == S_DIVM) begin
                     mean_ff <= neg_ff ? -16'({quo_ff[14:0], !trial[SqSumBits]})
                                       : 16'({quo_ff[14:0], !trial[SqSumBits]});
                     quo_ff <= sq_ff[0]; ch_ff <= 1'b0; state_ff <= S_DIVP;
                  end else begin
                     pw_ff[ch_ff] <= {quo_ff[29:0], !trial[SqSumBits]};
                     if ({1'b0, ch_ff} + 2'd1 == nch_eff) begin
                        state_ff <= S_OUT; ocnt_ff <= 1'b0; outv_ff <= 1'b1;
                     end else begin
                        ch_ff <= 1'b1; quo_ff <= sq_ff[1];
                     end
                  end
               end else begin
                  if (!trial[SqSumBits]) rem_ff <= trial[SqSumBits-1:0];
                  else rem_ff <= {rem_ff[SqSumBits-2:0], quo_ff[SqSumBits-1]};
                  quo_ff <= {quo_ff[SqSumBits-2:0], !trial[SqSumBits]};
                  bit_ff <= bit_ff + 6'd1;
               end
            end
            S_OUT: if (!rsp_stall) begin
               if ({1'b0, ocnt_ff} + 2'd1 == nch_eff) begin
                  outv_ff <= 1'b0; state_ff <= S_IDLE;
               end else ocnt_ff <= 1'b1;
            end
            S_WAIT: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = outv_ff;
   assign rsp_channel_out = ocnt_ff;
   assign rsp_peak = peak_ff;
   assign rsp_minimum = mini_ff;
   assign rsp_mean = mean_ff;
   assign rsp_power = pw_ff[ocnt_ff];
   assign rsp_last = ({1'b0, ocnt_ff} + 2'd1 == nch_eff);
`ifndef SYNTHESIS
   a_vout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_OUT) else $error("result outside output state");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !rsp_valid) else $error("pop during output");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_channel_out))
      else $error("stalled result dropped");
`endif
endmodule
`default_nettype wire

// ----- sv/windowed_audio_level_meter_unit.sv -----
`default_nettype none
// channel | dir | transfer when
// req_*   | in  | req_valid && !req_stall
// rsp_*   | out | rsp_valid && !rsp_stall
// csr_*   | in  | csr_valid && csr_ready
// a sample without block end is registered in the queue, then written to the
// store once the back end is idle; a block end sweeps the windows, each sample
// in a memory read state then an accumulate state, then runs (channels + 1)
// bit-serial divisions, then emits one result per cycle while rsp_stall is low
// after reset a clearing pass zeroes all 2048 words of the sample memory
// the 2-entry queue stalls req_ once it fills while the back end sweeps
module windowed_audio_level_meter_unit
   import walm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_channel,
   input  wire logic signed [15:0] req_sample,
   input  wire logic        req_end_of_block,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_channel_out,
   output logic signed [15:0] rsp_peak,
   output logic signed [15:0] rsp_minimum,
   output logic signed [15:0] rsp_mean,
   output logic [30:0]      rsp_power,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [10:0] csr_data
);
   logic [1:0]  nch_ff;
   logic [10:0] wlen_ff;
   item_type    in_item, q_item;
   logic        q_valid, q_pop;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         nch_ff <= 2'd2;
         wlen_ff <= 11'd1024;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrChannelCount: nch_ff <= csr_data[1:0];
            CsrWindowLen:    wlen_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign in_item = '{channel: req_channel, sample: req_sample, eob: req_end_of_block};

   walm_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_item(in_item), .nch(nch_ff),
      .q_valid, .q_pop, .q_item
   );
   walm_back u_back (
      .clock, .reset, .q_valid, .q_pop, .q_item, .nch(nch_ff), .wlen(wlen_ff),
      .rsp_valid, .rsp_stall, .rsp_channel_out, .rsp_peak, .rsp_minimum,
      .rsp_mean, .rsp_power, .rsp_last
   );
endmodule
`default_nettype wire

// ----- sim/windowed_audio_level_meter_unit_test.sv -----
`default_nettype none
module windowed_audio_level_meter_unit_test;
   import walm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic              channel_out;
      logic signed [15:0] peak;
      logic signed [15:0] minimum;
      logic signed [15:0] mean;
      logic [30:0]       power;
      logic              last;
   } level_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_channel = 1'b0;
   logic signed [15:0] req_sample = '0;
   logic req_end_of_block = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_channel_out;
   logic signed [15:0] rsp_peak, rsp_minimum, rsp_mean;
   logic [30:0] rsp_power;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [0:0] csr_index = CsrChannelCount;
   logic [10:0] csr_data = '0;

   windowed_audio_level_meter_unit DUT (.*);

   always #4 clock = ~clock;

   // meter model state
   logic signed [15:0] window_mem [MaxChannels][WindowDepth];
   int unsigned slot_ptr [MaxChannels];
   logic [1:0] chan_reg;
   logic [10:0] len_reg;
   level_type pending_levels [$];
   int error_count = 0;
   int cycle_count = 0;
   int sink_wait = 0;
   bit quiet_sink = 1'b0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic void meter_reset();
      for (int c = 0; c < MaxChannels; c++) begin
         slot_ptr[c] = 0;
         for (int k = 0; k < WindowDepth; k++) window_mem[c][k] = '0;
      end
      chan_reg = 2'd2;
      len_reg = 11'd1024;
   endfunction

   function automatic void meter_step(input logic ch, input logic signed [15:0] smp,
                                      input logic eob);
      int unsigned nch, len, pos;
      longint peak, mini, total, v, mean_v;
      longint sq [MaxChannels];
      level_type lv;
      nch = (chan_reg == 0) ? 1 : (chan_reg > MaxChannels) ? MaxChannels : chan_reg;
      len = (len_reg == 0) ? 1 : (len_reg > WindowDepth) ? WindowDepth : len_reg;
      if (ch < nch) begin
         window_mem[ch][slot_ptr[ch]] = smp;
         slot_ptr[ch] = (slot_ptr[ch] + 1) % WindowDepth;
      end
      if (!eob) return;
      peak = -32768;
      mini = 32767;
      total = 0;
      for (int c = 0; c < nch; c++) begin
         sq[c] = 0;
         for (int k = 1; k <= len; k++) begin
            pos = (slot_ptr[c] + WindowDepth - k) % WindowDepth;
            v = window_mem[c][pos];
            if (v > peak) peak = v;
            if (v < mini) mini = v;
            total += v;
            sq[c] += v * v;
         end
      end
      mean_v = total / longint'(nch * len);
      for (int c = 0; c < nch; c++) begin
         lv.channel_out = c[0];
         lv.peak = peak[15:0];
         lv.minimum = mini[15:0];
         lv.mean = mean_v[15:0];
         lv.power = 31'(sq[c] / len);
         lv.last = (c + 1 == nch);
         pending_levels.insert(pending_levels.size(), lv);
      end
   endfunction

   // valid stays up after a transfer until the next call or wait_drained drops it
   task automatic send_sample(input logic ch, input logic signed [15:0] smp, input logic eob,
                              input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_channel <= ch;
      req_sample <= smp;
      req_end_of_block <= eob;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      meter_step(ch, smp, eob);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [10:0] val);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CsrChannelCount) chan_reg = val[1:0];
      else len_reg = val;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 3000000) begin
         $display("FAIL windowed_audio_level_meter_unit");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_levels.size() == 0) begin
            report_mismatch("unexpected result", rsp_channel_out, -1);
         end else begin
            level_type lv;
            lv = pending_levels[0];
            pending_levels.delete(0);
            if (rsp_channel_out !== lv.channel_out)
               report_mismatch("channel_out", rsp_channel_out, lv.channel_out);
            if (rsp_peak !== lv.peak) report_mismatch("peak", rsp_peak, lv.peak);
            if (rsp_minimum !== lv.minimum) report_mismatch("minimum", rsp_minimum, lv.minimum);
            if (rsp_mean !== lv.mean) report_mismatch("mean", rsp_mean, lv.mean);
            if (rsp_power !== lv.power) report_mismatch("power", rsp_power, lv.power);
            if (rsp_last !== lv.last) report_mismatch("last", rsp_last, lv.last);
         end
         // back-pressure after each result, with quiet stretches
         sink_wait = quiet_sink ? 0 : $urandom_range(0, 10);
      end else if (sink_wait > 0) begin
         sink_wait--;
      end
      rsp_stall <= (sink_wait > 0);
   end

   task automatic test_extremes();
      send_sample(1'b0, 16'sh7fff, 1'b0);
      send_sample(1'b1, 16'sh8000, 1'b1);
      send_sample(1'b0, 16'sh8000, 1'b0);
      send_sample(1'b1, 16'sh7fff, 1'b1);
      send_sample(1'b0, 16'sh0000, 1'b1);
   endtask

   task automatic test_short_windows();
      write_csr(CsrWindowLen, 11'd1);
      send_sample(1'b0, 16'sh7fff, 1'b0);
      send_sample(1'b1, 16'sh7fff, 1'b1);
      send_sample(1'b0, -16'sd3, 1'b0);
      send_sample(1'b1, 16'sd2, 1'b1);
      write_csr(CsrWindowLen, 11'd0);
      send_sample(1'b0, 16'sh8000, 1'b1);
      write_csr(CsrWindowLen, 11'd2047);
      send_sample(1'b1, 16'sd5, 1'b1);
      write_csr(CsrWindowLen, 11'd3);
      send_sample(1'b0, -16'sd7, 1'b1);
   endtask

   task automatic test_channel_count();
      write_csr(CsrChannelCount, 11'd1);
      // channel 1 dropped but block end still honoured
      send_sample(1'b1, 16'sh1234, 1'b1);
      send_sample(1'b0, 16'sh4321, 1'b1);
      write_csr(CsrChannelCount, 11'd0);
      send_sample(1'b1, -16'sd100, 1'b1);
      write_csr(CsrChannelCount, 11'd3);
      send_sample(1'b1, -16'sd100, 1'b1);
      write_csr(CsrChannelCount, 11'd2);
   endtask

   task automatic test_random(input int count);
      logic signed [15:0] smp;
      for (int i = 0; i < count; i++) begin
         if (i % 70 == 0) write_csr(CsrWindowLen, 11'($urandom_range(1, 16)));
         if (i % 110 == 55) write_csr(CsrChannelCount, 11'($urandom_range(1, 2)));
         quiet_sink = (i % 60) > 45;
         case ($urandom_range(0, 3))
            0: smp = 16'sh7fff;
            1: smp = 16'sh8000;
            default: smp = 16'($urandom);
         endcase
         send_sample(1'($urandom_range(0, 1)), smp, ($urandom_range(0, 3) == 0), quiet_sink);
      end
   endtask

   initial begin
      meter_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_short_windows();
      test_channel_count();
      test_random(270);
      // one full-length sweep at the end
      write_csr(CsrWindowLen, 11'd1024);
      send_sample(1'b0, 16'sd9, 1'b1);
      wait_drained();
      if (error_count == 0) $display("PASS windowed_audio_level_meter_unit");
      else $display("FAIL windowed_audio_level_meter_unit");
      $finish;
   end
endmodule
`default_nettype wire
